@@ hw/rtl/plt_pkg.sv @@
// ============================================================================
// plt_pkg: shared types and constants for the positional list table
// Request and response item structs, request codes and status codes.
// ============================================================================
package plt_pkg;

    // Field widths
    localparam int IDX_W  = 5;
    localparam int KEY_W  = 64;
    localparam int REQ_W  = 3;
    localparam int STS_W  = 2;

    // Default list capacity
    localparam int PLT_DEPTH_DEF = 16;

    // Request codes (6 and 7 are unused and answered with bad index)
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 3'd0,
        REQ_DELETE   = 3'd1,
        REQ_LOCATE   = 3'd2,
        REQ_RETRIEVE = 3'd3,
        REQ_STEP     = 3'd4,
        REQ_CLEAR    = 3'd5
    } t_req_code;

    // Status codes
    typedef enum logic [STS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Request item
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             backward;
        logic [IDX_W-1:0] index;
        logic [KEY_W-1:0] name_key;
        logic [KEY_W-1:0] address_key;
    } t_req;

    // Response item
    typedef struct packed {
        logic [STS_W-1:0] status;
        logic             found;
        logic [IDX_W-1:0] result_index;
        logic [KEY_W-1:0] result_name;
        logic [KEY_W-1:0] result_address;
        logic [IDX_W-1:0] entry_total;
    } t_rsp;

endpackage

@@ hw/rtl/plt_ram.sv @@
// ============================================================================
// plt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents undefined at reset.
// ============================================================================
module plt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/positional_list_table.sv @@
// ============================================================================
// positional_list_table: ordered list of name/address entries
// Insert, delete, locate, retrieve, next/previous and clear on a list held
// in one RAM, with a small sequencer moving or scanning one entry at a time.
// ============================================================================
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------
//  request   | start in, busy out     | i_req  (plt_pkg::t_req)
//  response  | o_done out (1 cycle)   | o_rsp  (plt_pkg::t_rsp)
//
//  Every RAM move or compare is a read, then a write or compare,
//  set by the single registered read port of the entry RAM.
//  Insert shifts each later entry up, then writes the new one; delete
//  shifts each later entry down; locate scans entries from the head;
//  retrieve reads one entry. Next, previous, clear and rejected requests
//  are answered straight from idle.
//  busy is high while a request is in the sequencer; o_done pulses for one
//  cycle with the response and cannot be held off.
//  Reset empties the list; the RAM needs no clearing.
//
module positional_list_table #(
    parameter int DEPTH = plt_pkg::PLT_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  plt_pkg::t_req i_req,
    output logic          o_done,
    output plt_pkg::t_rsp o_rsp
);
    import plt_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CW1  = CW + 1;
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam int WW   = 2 * KEY_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_LOC_RD,
        S_LOC_CMP,
        S_RET_RD,
        S_RET_OUT
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_ptr;
    logic [CW-1:0]    r_idx;
    logic [KEY_W-1:0] r_name;
    logic [KEY_W-1:0] r_addr;
    logic             r_done;
    t_rsp             r_rsp;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [WW-1:0]    w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [WW-1:0]    w_rdata;
    logic [CMPW-1:0]  w_idx;
    logic [CMPW-1:0]  w_cnt;
    logic             w_match;

    // Narrow an internal index or count to the port field width
    function automatic logic [IDX_W-1:0] f_fld(input logic [CMPW-1:0] v);
        return v[IDX_W-1:0];
    endfunction

    // Build one response item
    function automatic t_rsp f_rsp(input t_status          st,
                                   input logic             fnd,
                                   input logic [IDX_W-1:0] ridx,
                                   input logic [KEY_W-1:0] nm,
                                   input logic [KEY_W-1:0] ad,
                                   input logic [IDX_W-1:0] tot);
        t_rsp rsp;
        rsp.status         = st;
        rsp.found          = fnd;
        rsp.result_index   = ridx;
        rsp.result_name    = nm;
        rsp.result_address = ad;
        rsp.entry_total    = tot;
        return rsp;
    endfunction

    // Entry store: {name, address} per entry
    plt_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // RAM port control from the sequencer state
    always_comb begin
        w_we    = (r_state == S_INS_WR) || (r_state == S_DEL_WR) || (r_state == S_INS_PUT);
        w_waddr = AW'(r_ptr);
        w_wdata = (r_state == S_INS_PUT) ? {r_name, r_addr} : w_rdata;
        unique case (r_state)
            S_INS_RD: w_raddr = AW'(r_ptr - CW'(1));
            S_DEL_RD: w_raddr = AW'(r_ptr + CW'(1));
            default:  w_raddr = AW'(r_ptr);
        endcase
    end

    // Compare unit for locate: a match on name or on address
    assign w_match = (w_rdata[WW-1:KEY_W] == r_name) || (w_rdata[KEY_W-1:0] == r_addr);

    assign w_idx = CMPW'(i_req.index);
    assign w_cnt = CMPW'(r_cnt);

    // Sequencer, list count and registered response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_name <= i_req.name_key;
                        r_addr <= i_req.address_key;
                        r_idx  <= CW'(w_idx);
                        unique case (t_req_code'(i_req.req_type))
                            REQ_INSERT: begin
                                if (w_idx > w_cnt) begin
                                    r_done <= 1'b1;
                                    r_rsp  <= f_rsp(ST_BAD_INDEX, 1'b0, '0, '0, '0,
                                                    f_fld(w_cnt));
                                end else if (w_cnt == CMPW'(DEPTH)) begin
                                    r_done <= 1'b1;
                                    r_rsp  <= f_rsp(ST_FULL, 1'b0, '0, '0, '0,
                                                    f_fld(w_cnt));
                                end else begin
                                    r_ptr   <= r_cnt;
                                    r_state <= (w_cnt > w_idx) ? S_INS_RD : S_INS_PUT;
                                end
                            end
                            REQ_DELETE: begin
                                if (w_idx >= w_cnt) begin
                                    r_done <= 1'b1;
                                    r_rsp  <= f_rsp(ST_BAD_INDEX, 1'b0, i_req.index, '0, '0,
                                                    f_fld(w_cnt));
                                end else if (w_idx + CMPW'(1) < w_cnt) begin
                                    r_ptr   <= CW'(w_idx);
                                    r_state <= S_DEL_RD;
                                end else begin
                                    // last entry: nothing to move
                                    r_cnt  <= r_cnt - CW'(1);
                                    r_done <= 1'b1;
                                    r_rsp  <= f_rsp(ST_OK, 1'b0, i_req.index, '0, '0,
                                                    f_fld(w_cnt - CMPW'(1)));
                                end
                            end
                            REQ_LOCATE: begin
                                r_ptr <= '0;
                                if (r_cnt == '0) begin
                                    r_done <= 1'b1;
                                    r_rsp  <= f_rsp(ST_OK, 1'b0, '0, '0, '0, '0);
                                end else begin
                                    r_state <= S_LOC_RD;
                                end
                            end
                            REQ_RETRIEVE: begin
                                if (w_idx >= w_cnt) begin
                                    r_done <= 1'b1;
                                    r_rsp  <= f_rsp(ST_BAD_INDEX, 1'b0, '0, '0, '0,
                                                    f_fld(w_cnt));
                                end else begin
                                    r_ptr   <= CW'(w_idx);
                                    r_state <= S_RET_RD;
                                end
                            end
                            REQ_STEP: begin
                                r_done <= 1'b1;
                                if ((w_idx >= w_cnt) || (i_req.backward && w_idx == '0)) begin
                                    r_rsp <= f_rsp(ST_BAD_INDEX, 1'b0, '0, '0, '0,
                                                   f_fld(w_cnt));
                                end else if (i_req.backward) begin
                                    r_rsp <= f_rsp(ST_OK, 1'b0, i_req.index - IDX_W'(1),
                                                   '0, '0, f_fld(w_cnt));
                                end else begin
                                    r_rsp <= f_rsp(ST_OK, 1'b0, i_req.index + IDX_W'(1),
                                                   '0, '0, f_fld(w_cnt));
                                end
                            end
                            REQ_CLEAR: begin
                                r_cnt  <= '0;
                                r_done <= 1'b1;
                                r_rsp  <= f_rsp(ST_OK, 1'b0, '0, '0, '0, '0);
                            end
                            default: begin
                                r_done <= 1'b1;
                                r_rsp  <= f_rsp(ST_BAD_INDEX, 1'b0, '0, '0, '0,
                                                f_fld(w_cnt));
                            end
                        endcase
                    end
                end

                // Insert: move entry ptr-1 up to ptr, down to the insert point
                S_INS_RD: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    r_ptr   <= r_ptr - CW'(1);
                    r_state <= ((r_ptr - CW'(1)) > r_idx) ? S_INS_RD : S_INS_PUT;
                end
                S_INS_PUT: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_done  <= 1'b1;
                    r_rsp   <= f_rsp(ST_OK, 1'b0, f_fld(CMPW'(r_idx)), '0, '0,
                                     f_fld(CMPW'(r_cnt + CW'(1))));
                    r_state <= S_IDLE;
                end

                // Delete: move entry ptr+1 down to ptr, up to the list end
                S_DEL_RD: begin
                    r_state <= S_DEL_WR;
                end
                S_DEL_WR: begin
                    r_ptr <= r_ptr + CW'(1);
                    if (CW1'(r_ptr) + CW1'(2) < CW1'(r_cnt)) begin
                        r_state <= S_DEL_RD;
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_done  <= 1'b1;
                        r_rsp   <= f_rsp(ST_OK, 1'b0, f_fld(CMPW'(r_idx)), '0, '0,
                                         f_fld(CMPW'(r_cnt - CW'(1))));
                        r_state <= S_IDLE;
                    end
                end

                // Locate: scan from the head, first match wins
                S_LOC_RD: begin
                    r_state <= S_LOC_CMP;
                end
                S_LOC_CMP: begin
                    if (w_match) begin
                        r_done  <= 1'b1;
                        r_rsp   <= f_rsp(ST_OK, 1'b1, f_fld(CMPW'(r_ptr)), '0, '0,
                                         f_fld(w_cnt));
                        r_state <= S_IDLE;
                    end else if (CW1'(r_ptr) + CW1'(1) == CW1'(r_cnt)) begin
                        r_done  <= 1'b1;
                        r_rsp   <= f_rsp(ST_OK, 1'b0, f_fld(w_cnt), '0, '0, f_fld(w_cnt));
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr   <= r_ptr + CW'(1);
                        r_state <= S_LOC_RD;
                    end
                end

                // Retrieve: one read
                S_RET_RD: begin
                    r_state <= S_RET_OUT;
                end
                S_RET_OUT: begin
                    r_done  <= 1'b1;
                    r_rsp   <= f_rsp(ST_OK, 1'b0, f_fld(CMPW'(r_ptr)),
                                     w_rdata[WW-1:KEY_W], w_rdata[KEY_W-1:0], f_fld(w_cnt));
                    r_state <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ sim/plt_checker.sv @@
// ============================================================================
// plt_checker: response predictor and scoreboard for the positional list table
// Watches the request and response channels of the list table. Keeps its own
// copy of the list, works out the expected response for each accepted request
// item, and compares every response item field by field, oldest first.
// ============================================================================
module plt_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  plt_pkg::t_req i_req,
    input  logic          i_done,
    input  plt_pkg::t_rsp i_rsp,
    output int            o_errors,
    output int            o_pending,
    output int            o_list_len
);
    timeunit 1ns;
    timeprecision 1ps;
    import plt_pkg::*;

    localparam int DEPTH     = PLT_DEPTH_DEF;
    localparam int MAX_LINES = 40;

    // Shadow copy of the list
    logic [KEY_W-1:0] slot_name [DEPTH];
    logic [KEY_W-1:0] slot_addr [DEPTH];
    int               list_len;

    // Responses owed by the block, oldest first
    t_rsp rsp_due_q [$];
    int   err_count;

    assign o_errors = err_count;

    // One line per mismatch; printing is capped, counting is not
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < MAX_LINES)
            $display("[%0t] response mismatch on %s: got %0h, expected %0h",
                     $time, what, got, want);
        err_count++;
    endtask

    // Apply one request to the shadow list and return the response it earns
    function automatic t_rsp list_apply(input t_req r);
        t_rsp p;
        int   k;
        int   hit;
        p = '0;
        case (r.req_type)
            REQ_INSERT: begin
                if (r.index > list_len) begin
                    p.status = ST_BAD_INDEX;
                end else if (list_len >= DEPTH) begin
                    p.status = ST_FULL;
                end else begin
                    // open a slot at index, later entries move up
                    for (k = list_len; k > r.index; k--) begin
                        slot_name[k] = slot_name[k-1];
                        slot_addr[k] = slot_addr[k-1];
                    end
                    slot_name[r.index] = r.name_key;
                    slot_addr[r.index] = r.address_key;
                    list_len++;
                    p.result_index = r.index;
                end
            end
            REQ_DELETE: begin
                p.result_index = r.index;
                if (r.index >= list_len) begin
                    p.status = ST_BAD_INDEX;
                end else begin
                    // close the gap, later entries move down
                    for (k = r.index; k + 1 < list_len; k++) begin
                        slot_name[k] = slot_name[k+1];
                        slot_addr[k] = slot_addr[k+1];
                    end
                    list_len--;
                end
            end
            REQ_LOCATE: begin
                // first entry matching on name or on address; count if none
                hit = list_len;
                for (k = list_len - 1; k >= 0; k--) begin
                    if (slot_name[k] == r.name_key || slot_addr[k] == r.address_key)
                        hit = k;
                end
                p.found        = (hit < list_len);
                p.result_index = hit[IDX_W-1:0];
            end
            REQ_RETRIEVE: begin
                if (r.index >= list_len) begin
                    p.status = ST_BAD_INDEX;
                end else begin
                    p.result_index   = r.index;
                    p.result_name    = slot_name[r.index];
                    p.result_address = slot_addr[r.index];
                end
            end
            REQ_STEP: begin
                if (r.index >= list_len || (r.backward && r.index == 0))
                    p.status = ST_BAD_INDEX;
                else if (r.backward)
                    p.result_index = r.index - 1'b1;
                else
                    p.result_index = r.index + 1'b1;
            end
            REQ_CLEAR: begin
                list_len = 0;
            end
            default: begin
                p.status = ST_BAD_INDEX;
            end
        endcase
        p.entry_total = list_len[IDX_W-1:0];
        return p;
    endfunction

    // Predict on accept, compare on response strobe
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            list_len = 0;
            rsp_due_q.delete();
        end else begin
            if (i_start && !i_busy)
                rsp_due_q.push_back(list_apply(i_req));
            if (i_done) begin
                if (rsp_due_q.size() == 0) begin
                    report_mismatch("unsolicited response, entry_total",
                                    i_rsp.entry_total, '0);
                end else begin
                    want = rsp_due_q.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", i_rsp.status, want.status);
                    if (i_rsp.found !== want.found)
                        report_mismatch("found", i_rsp.found, want.found);
                    if (i_rsp.result_index !== want.result_index)
                        report_mismatch("result_index", i_rsp.result_index,
                                        want.result_index);
                    if (i_rsp.result_name !== want.result_name)
                        report_mismatch("result_name", i_rsp.result_name,
                                        want.result_name);
                    if (i_rsp.result_address !== want.result_address)
                        report_mismatch("result_address", i_rsp.result_address,
                                        want.result_address);
                    if (i_rsp.entry_total !== want.entry_total)
                        report_mismatch("entry_total", i_rsp.entry_total,
                                        want.entry_total);
                end
            end
        end
        o_pending  <= rsp_due_q.size();
        o_list_len <= list_len;
    end

    initial begin
        err_count = 0;
        list_len  = 0;
    end

endmodule

@@ sim/tb_positional_list_table.sv @@
// ============================================================================
// tb_positional_list_table: testbench top for the positional list table
// Drives a short directed sequence and then random request items in three
// pacing phases, with drains between them. The checker predicts and scores
// every response; this top gives the verdict once all responses are in.
// ============================================================================
module tb_positional_list_table;
    timeunit 1ns;
    timeprecision 1ps;
    import plt_pkg::*;

    localparam int            RAND_PER_PHASE = 135;
    localparam int            FILL_SPAN      = 45;
    localparam int            TAIL_CYCLES    = 2 * PLT_DEPTH_DEF + 8;
    localparam int            CYCLE_LIMIT    = 400000;
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
    localparam logic [KEY_W-1:0] KEY_ONES     = '1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req req_item = '0;
    logic busy;
    logic done;
    t_rsp rsp_item;

    int errors;
    int pending;
    int list_len;
    int idle_pct;
    int cycle_cnt;

    logic [KEY_W-1:0] key_pool [8];

    always #1 i_clk = ~i_clk;

    positional_list_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req_item),
        .o_done  (done),
        .o_rsp   (rsp_item)
    );

    plt_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (req_item),
        .i_done     (done),
        .i_rsp      (rsp_item),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_list_len (list_len)
    );

    // Run guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("positional_list_table verification failed");
            $finish;
        end
    end

    function automatic t_req mk_req(input logic [REQ_W-1:0] op, input logic bw,
                                    input logic [IDX_W-1:0] idx,
                                    input logic [KEY_W-1:0] nm,
                                    input logic [KEY_W-1:0] ad);
        t_req r;
        r.req_type    = op;
        r.backward    = bw;
        r.index       = idx;
        r.name_key    = nm;
        r.address_key = ad;
        return r;
    endfunction

    // Half the keys come from a small pool so locates find things
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(1))
            return key_pool[3'($urandom_range(7))];
        return {$urandom, $urandom};
    endfunction

    // Random request shaped around the current list length
    function automatic t_req rand_list_req(input int len, input bit fill_bias);
        logic [REQ_W-1:0] op;
        logic [IDX_W-1:0] idx;
        int               roll;
        roll = $urandom_range(99);
        if (fill_bias) begin
            if (roll < 72)      op = REQ_INSERT;
            else if (roll < 80) op = REQ_DELETE;
            else if (roll < 88) op = REQ_LOCATE;
            else if (roll < 94) op = REQ_RETRIEVE;
            else                op = REQ_STEP;
        end else begin
            if (roll < 24)      op = REQ_INSERT;
            else if (roll < 44) op = REQ_DELETE;
            else if (roll < 60) op = REQ_LOCATE;
            else if (roll < 74) op = REQ_RETRIEVE;
            else if (roll < 90) op = REQ_STEP;
            else if (roll < 93) op = REQ_CLEAR;
            else if (roll < 96) op = REQ_SPARE_LO;
            else                op = REQ_SPARE_HI;
        end
        // mostly in or just past range, sometimes anywhere
        roll = $urandom_range(99);
        if (roll < 85)      idx = IDX_W'($urandom_range(len));
        else if (roll < 95) idx = IDX_W'($urandom_range(PLT_DEPTH_DEF));
        else                idx = IDX_W'($urandom_range(31));
        return mk_req(op, 1'($urandom_range(1)), idx, pick_key(), pick_key());
    endfunction

    // Offer one item after a random gap, return at the edge that takes it
    task automatic send_req(input t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        req_item <= r;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold off until every owed response has come back
    task automatic drain_rsp();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int ph;
        int n;
        int k;
        cycle_cnt = 0;
        idle_pct  = 28;
        key_pool[0] = '0;
        key_pool[1] = KEY_ONES;
        for (k = 2; k < 8; k++)
            key_pool[k] = {$urandom, $urandom};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, edge positions, key extremes, spare codes
        send_req(mk_req(REQ_RETRIEVE, 1'b0, 5'd0, '0, '0));
        send_req(mk_req(REQ_STEP, 1'b0, 5'd0, '0, '0));
        send_req(mk_req(REQ_DELETE, 1'b0, 5'd0, '0, '0));
        send_req(mk_req(REQ_LOCATE, 1'b0, 5'd0, key_pool[2], key_pool[3]));
        send_req(mk_req(REQ_INSERT, 1'b0, 5'd1, key_pool[2], key_pool[3]));
        send_req(mk_req(REQ_INSERT, 1'b0, 5'd0, KEY_ONES, '0));
        send_req(mk_req(REQ_INSERT, 1'b1, 5'd1, '0, KEY_ONES));
        send_req(mk_req(REQ_INSERT, 1'b0, 5'd0, key_pool[2], key_pool[3]));
        send_req(mk_req(REQ_INSERT, 1'b0, 5'd1, key_pool[4], key_pool[5]));
        for (k = 0; k < 4; k++)
            send_req(mk_req(REQ_RETRIEVE, 1'b0, k[IDX_W-1:0], '0, '0));
        send_req(mk_req(REQ_LOCATE, 1'b0, 5'd0, key_pool[4], key_pool[6]));
        send_req(mk_req(REQ_LOCATE, 1'b0, 5'd0, key_pool[7], KEY_ONES));
        send_req(mk_req(REQ_LOCATE, 1'b0, 5'd0, key_pool[6], key_pool[7]));
        send_req(mk_req(REQ_STEP, 1'b0, 5'd3, '0, '0));
        send_req(mk_req(REQ_STEP, 1'b1, 5'd0, '0, '0));
        send_req(mk_req(REQ_STEP, 1'b1, 5'd3, '0, '0));
        send_req(mk_req(REQ_STEP, 1'b0, 5'd31, '0, '0));
        send_req(mk_req(REQ_DELETE, 1'b0, 5'd3, '0, '0));
        send_req(mk_req(REQ_DELETE, 1'b0, 5'd0, '0, '0));
        send_req(mk_req(REQ_DELETE, 1'b1, 5'd31, KEY_ONES, KEY_ONES));
        send_req(mk_req(REQ_SPARE_LO, 1'b0, 5'd0, '0, '0));
        send_req(mk_req(REQ_SPARE_HI, 1'b1, 5'd1, '0, '0));
        send_req(mk_req(REQ_CLEAR, 1'b0, 5'd0, '0, '0));
        drain_rsp();

        // Random: sender pacing at 28%, then 64%, then back to back;
        // fill-heavy stretches push the list to full and past it
        for (ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 28 : (ph == 1) ? 64 : 0;
            for (n = 0; n < RAND_PER_PHASE; n++)
                send_req(rand_list_req(list_len, ((n / FILL_SPAN) % 2) == 0));
            drain_rsp();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("positional_list_table verification clean");
        else
            $display("positional_list_table verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/plt_pkg.sv
hw/rtl/plt_ram.sv
hw/rtl/positional_list_table.sv
sim/plt_checker.sv
sim/tb_positional_list_table.sv
